// ===== rtl/core/kbm_pkg.sv =====
package kbm_pkg;

    // Keybed size and field widths.
    localparam int NUM_KEYS     = 64;
    localparam int KEY_W        = 6;
    localparam int TIME_W       = 16;
    localparam int NOTE_W       = 8;
    localparam int CFG_W        = 7;
    localparam int VEL_W        = 7;
    localparam int CFG_IDX_W    = 1;

    // Only keys that the key field can name need a flag.
    localparam int FLAG_DEPTH   = (NUM_KEYS < (1 << KEY_W)) ? NUM_KEYS : (1 << KEY_W);
    localparam int FLAG_IDX_W   = (FLAG_DEPTH > 1) ? $clog2(FLAG_DEPTH) : 1;
    localparam int RANGE_W      = KEY_W + 2;
    localparam logic [RANGE_W-1:0] NUM_KEYS_V = RANGE_W'(NUM_KEYS);

    // Velocity curve: t clamped to T_MIN..T_MAX, table indexed by T_MAX - t.
    localparam int T_MIN        = 2;
    localparam int T_MAX        = 250;
    localparam int CURVE_LEN    = T_MAX - T_MIN + 1;
    localparam int CURVE_IDX_W  = $clog2(CURVE_LEN);
    localparam int CURVE_SPAN   = T_MAX - T_MIN;
    localparam int CURVE_SCALE  = 126;
    localparam int EXP_NUM      = 63;
    localparam int EXP_DEN      = 10;
    localparam int BIG_W        = 640;
    localparam int ROM_ADDR_W   = $clog2(CURVE_LEN * VEL_W);

    localparam logic [CFG_W-1:0] START_NOTE_RST = CFG_W'(36);
    localparam logic [CFG_W-1:0] TRIG_VEL_RST   = CFG_W'(127);

    localparam logic [CFG_IDX_W-1:0] CFG_START_NOTE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_VEL   = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        KIND_TOUCHED  = 2'd0,
        KIND_PRESSED  = 2'd1,
        KIND_TOP      = 2'd2,
        KIND_RELEASED = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        MSG_HT_NOTE_ON = 2'd0,
        MSG_NOTE_ON    = 2'd1,
        MSG_NOTE_OFF   = 2'd2
    } t_msg;

    typedef struct packed {
        logic                  en;
        logic [FLAG_IDX_W-1:0] idx;
        logic                  value;
    } t_flag_wr;

    typedef struct packed {
        logic              has;
        t_msg              msg_type;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  velocity;
    } t_result;

    // Entry n is 1 plus the count of k in 1..126 with
    // k^10 * 248^63 <= 126^10 * n^63, evaluated exactly on wide integers.
    function automatic logic [CURVE_LEN*VEL_W-1:0] build_vel_curve();
        logic [CURVE_LEN*VEL_W-1:0] curve;
        logic [BIG_W-1:0]           base;
        logic [BIG_W-1:0]           rhs;
        logic [BIG_W-1:0]           lhs;
        int                         i;
        int                         n;
        int                         k;
        logic                       done;
        curve = '0;
        base  = BIG_W'(1);
        for (i = 0; i < EXP_NUM; i++) begin
            base = base * BIG_W'(CURVE_SPAN);
        end
        k = 0;
        for (n = 0; n < CURVE_LEN; n++) begin
            rhs = BIG_W'(1);
            for (i = 0; i < EXP_DEN; i++) begin
                rhs = rhs * BIG_W'(CURVE_SCALE);
            end
            for (i = 0; i < EXP_NUM; i++) begin
                rhs = rhs * BIG_W'(n);
            end
            done = 1'b0;
            while ((k < CURVE_SCALE) && !done) begin
                lhs = base;
                for (i = 0; i < EXP_DEN; i++) begin
                    lhs = lhs * BIG_W'(k + 1);
                end
                if (lhs <= rhs) begin
                    k = k + 1;
                end else begin
                    done = 1'b1;
                end
            end
            curve[n*VEL_W +: VEL_W] = VEL_W'(k + 1);
        end
        return curve;
    endfunction

    localparam logic [CURVE_LEN*VEL_W-1:0] VEL_CURVE = build_vel_curve();

endpackage

// ===== rtl/core/keybed_to_midi_note_events.sv =====
// Turns key events from a dual-contact keybed scanner into MIDI note requests.
// One request can be accepted every clock cycle while o_in_stall is low; its
// result, if any, passes through the input register and then the result
// register, with the flag lookup, velocity ROM and note add between them.
// The result register lets a new request enter while a finished one is still
// stalled. Touched gives a high-trigger note-on, pressed gives a note-on with
// a velocity from the contact time (once per key until its top event), top
// gives a note-off, released and keys beyond the keybed give nothing. The
// per-key flags clear at reset, with no clearing pass.
module keybed_to_midi_note_events
    import kbm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_kind,
    input  logic [KEY_W-1:0]     i_key_index,
    input  logic [TIME_W-1:0]    i_delta_time,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [1:0]           o_message_type,
    output logic [NOTE_W-1:0]    o_note,
    output logic [VEL_W-1:0]     o_velocity,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic               r_in_vld;
    t_kind              r_kind;
    logic [KEY_W-1:0]   r_key;
    logic [TIME_W-1:0]  r_dt;

    logic               r_out_vld;
    t_msg               r_msg;
    logic [NOTE_W-1:0]  r_note;
    logic [VEL_W-1:0]   r_vel;

    logic [CFG_W-1:0]   r_start_note;
    logic [CFG_W-1:0]   r_trig_vel;

    logic               out_advance;
    logic               in_ready;
    logic               flag;
    logic [VEL_W-1:0]   press_vel;
    t_result            result;
    t_flag_wr           dec_wr;
    t_flag_wr           flag_wr;

    assign out_advance = !r_out_vld || !i_out_stall;
    assign in_ready    = !r_in_vld || out_advance;
    assign o_in_stall  = !in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_note <= START_NOTE_RST;
            r_trig_vel   <= TRIG_VEL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_START_NOTE: r_start_note <= i_cfg_data;
                CFG_TRIG_VEL:   r_trig_vel   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in_valid) begin
            r_kind <= t_kind'(i_kind);
            r_key  <= i_key_index;
            r_dt   <= i_delta_time;
        end
    end

    kbm_key_flags u_flags (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_idx  (FLAG_IDX_W'(r_key)),
        .i_wr      (flag_wr),
        .o_rd_flag (flag)
    );

    kbm_vel_rom u_vel_rom (
        .i_delta_time (r_dt),
        .o_velocity   (press_vel)
    );

    kbm_event_decode u_decode (
        .i_valid          (r_in_vld),
        .i_kind           (r_kind),
        .i_key_index      (r_key),
        .i_flag           (flag),
        .i_press_velocity (press_vel),
        .i_start_note     (r_start_note),
        .i_trig_vel       (r_trig_vel),
        .o_result         (result),
        .o_flag_wr        (dec_wr)
    );

    // The flag changes in the same edge the request leaves the input register,
    // so the next request for the same key already sees it.
    always_comb begin
        flag_wr    = dec_wr;
        flag_wr.en = dec_wr.en && out_advance;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_advance) begin
            r_out_vld <= result.has;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_advance && result.has) begin
            r_msg  <= result.msg_type;
            r_note <= result.note;
            r_vel  <= result.velocity;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_message_type = r_msg;
    assign o_note         = r_note;
    assign o_velocity     = r_vel;

endmodule

// ===== rtl/core/kbm_key_flags.sv =====
module kbm_key_flags
    import kbm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [FLAG_IDX_W-1:0] i_rd_idx,
    input  t_flag_wr              i_wr,
    output logic                  o_rd_flag
);

    logic [(1 << FLAG_IDX_W)-1:0] r_flags;
    logic [(1 << FLAG_IDX_W)-1:0] n_flags;

    always_comb begin
        n_flags = r_flags;
        if (i_wr.en) begin
            n_flags[i_wr.idx] = i_wr.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else begin
            r_flags <= n_flags;
        end
    end

    assign o_rd_flag = r_flags[i_rd_idx];

endmodule

// ===== rtl/core/kbm_vel_rom.sv =====
module kbm_vel_rom
    import kbm_pkg::*;
(
    input  logic [TIME_W-1:0] i_delta_time,
    output logic [VEL_W-1:0]  o_velocity
);

    logic [TIME_W-1:0]      t_clamped;
    logic [CURVE_IDX_W-1:0] rom_idx;
    logic [ROM_ADDR_W-1:0]  rom_bit;

    always_comb begin
        if (i_delta_time < TIME_W'(T_MIN)) begin
            t_clamped = TIME_W'(T_MIN);
        end else if (i_delta_time > TIME_W'(T_MAX)) begin
            t_clamped = TIME_W'(T_MAX);
        end else begin
            t_clamped = i_delta_time;
        end
        rom_idx = CURVE_IDX_W'(TIME_W'(T_MAX) - t_clamped);
        rom_bit = ROM_ADDR_W'(rom_idx) * ROM_ADDR_W'(VEL_W);
    end

    assign o_velocity = VEL_CURVE[rom_bit +: VEL_W];

endmodule

// ===== rtl/core/kbm_event_decode.sv =====
module kbm_event_decode
    import kbm_pkg::*;
(
    input  logic              i_valid,
    input  t_kind             i_kind,
    input  logic [KEY_W-1:0]  i_key_index,
    input  logic              i_flag,
    input  logic [VEL_W-1:0]  i_press_velocity,
    input  logic [CFG_W-1:0]  i_start_note,
    input  logic [CFG_W-1:0]  i_trig_vel,
    output t_result           o_result,
    output t_flag_wr          o_flag_wr
);

    logic in_range;

    assign in_range = {{(RANGE_W - KEY_W){1'b0}}, i_key_index} < NUM_KEYS_V;

    always_comb begin
        o_result.has      = 1'b0;
        o_result.msg_type = MSG_HT_NOTE_ON;
        o_result.note     = NOTE_W'(i_start_note) + NOTE_W'(i_key_index);
        o_result.velocity = '0;
        o_flag_wr.en      = 1'b0;
        o_flag_wr.idx     = FLAG_IDX_W'(i_key_index);
        o_flag_wr.value   = 1'b0;
        if (i_valid && in_range) begin
            case (i_kind)
                KIND_TOUCHED: begin
                    o_result.has      = 1'b1;
                    o_result.msg_type = MSG_HT_NOTE_ON;
                    o_result.velocity = i_trig_vel;
                end
                KIND_PRESSED: begin
                    // A repeated press on a sounding key is swallowed.
                    if (!i_flag) begin
                        o_result.has      = 1'b1;
                        o_result.msg_type = MSG_NOTE_ON;
                        o_result.velocity = i_press_velocity;
                        o_flag_wr.en      = 1'b1;
                        o_flag_wr.value   = 1'b1;
                    end
                end
                KIND_TOP: begin
                    o_result.has      = 1'b1;
                    o_result.msg_type = MSG_NOTE_OFF;
                    o_flag_wr.en      = 1'b1;
                    o_flag_wr.value   = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/kbm_checker.sv =====
module kbm_checker
    import kbm_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic [1:0]           o_message_type,
    input logic [NOTE_W-1:0]    o_note,
    input logic [VEL_W-1:0]     o_velocity
);

    // A stalled result request must hold until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_message_type) && $stable(o_note)
            && $stable(o_velocity))
        else $error("result request changed while stalled");

    a_type_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_message_type == MSG_HT_NOTE_ON
            || o_message_type == MSG_NOTE_ON || o_message_type == MSG_NOTE_OFF))
        else $error("illegal message type");

    a_off_zero_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_message_type == MSG_NOTE_OFF |-> o_velocity == '0)
        else $error("note-off with nonzero velocity");

    // The velocity curve never drops below one.
    a_on_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_message_type == MSG_NOTE_ON |-> o_velocity != '0)
        else $error("note-on with zero velocity");

endmodule

bind keybed_to_midi_note_events kbm_checker u_kbm_checker (.*);
